// ===== rtl/dual_mode_counter_seven_segment_top_assert.svh =====
// assertion macros for the dual mode counter checker
`ifndef DUAL_MODE_COUNTER_SEVEN_SEGMENT_TOP_ASSERT_SVH
`define DUAL_MODE_COUNTER_SEVEN_SEGMENT_TOP_ASSERT_SVH

// checked on every edge, reset included
`define DMCSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// checked outside reset
`define DMCSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== rtl/dmcss_pkg.sv =====
// ----------------------------------------------------------------------------
// dmcss_pkg
// Shared types, constants and table functions of the dual mode counter.
// ----------------------------------------------------------------------------
package dmcss_pkg;

  localparam int unsigned ValueW  = 7;
  localparam int unsigned LightW  = 10;
  localparam int unsigned SegW    = 7;
  localparam int unsigned EventW  = 2;
  localparam int unsigned DigitW  = 4;

  localparam logic [LightW-1:0] THRESHOLD_RESET = 10'd500;
  localparam logic [ValueW-1:0] DECIMAL_MAX     = 7'd99;
  localparam logic [ValueW-1:0] PRIME_TOP       = 7'd97;
  localparam logic [ValueW-1:0] MOTOR_COUNT     = 7'd5;

  localparam logic [EventW-1:0] EV_NONE  = 2'd0;
  localparam logic [EventW-1:0] EV_UP    = 2'd1;
  localparam logic [EventW-1:0] EV_DOWN  = 2'd2;
  localparam logic [EventW-1:0] EV_CLEAR = 2'd3;

  localparam int unsigned PrimeTotal = 25;

  localparam logic [ValueW-1:0] PRIME_TABLE [PrimeTotal] = '{
    7'd2,  7'd3,  7'd5,  7'd7,  7'd11, 7'd13, 7'd17, 7'd19, 7'd23,
    7'd29, 7'd31, 7'd37, 7'd41, 7'd43, 7'd47, 7'd53, 7'd59, 7'd61,
    7'd67, 7'd71, 7'd73, 7'd79, 7'd83, 7'd89, 7'd97
  };

  localparam logic [SegW-1:0] SEG_TABLE [10] = '{
    7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B
  };

  typedef struct packed {
    logic              up_button_n;
    logic              down_button_n;
    logic              clear_button_n;
    logic              prime_mode;
    logic [LightW-1:0] light_level;
  } sample_t;

  typedef struct packed {
    logic [EventW-1:0] key_event;
    logic              enabled;
    logic [ValueW-1:0] shown_value;
    logic              motor_on;
  } result_t;

  // smallest prime above c, 0 past the table
  function automatic logic [ValueW-1:0] next_prime(input logic [ValueW-1:0] c);
    logic [ValueW-1:0] r;
    r = '0;
    for (int i = PrimeTotal - 1; i >= 0; i--) begin
      if (PRIME_TABLE[i] > c) begin
        r = PRIME_TABLE[i];
      end
    end
    return r;
  endfunction

  // largest prime below c, 97 below the table or above the top
  function automatic logic [ValueW-1:0] prev_prime(input logic [ValueW-1:0] c);
    logic [ValueW-1:0] r;
    r = PRIME_TOP;
    for (int i = 0; i < PrimeTotal; i++) begin
      if (PRIME_TABLE[i] < c) begin
        r = PRIME_TABLE[i];
      end
    end
    if (c > PRIME_TOP) begin
      r = PRIME_TOP;
    end
    return r;
  endfunction

  function automatic logic [SegW-1:0] seg_of(input logic [DigitW-1:0] d);
    logic [SegW-1:0] r;
    r = '0;
    if (d < DigitW'(10)) begin
      r = SEG_TABLE[d];
    end
    return r;
  endfunction

endpackage

// ===== rtl/dmcss_core.sv =====
// ----------------------------------------------------------------------------
// dmcss_core
// Button edge detection, enable compare and the decimal and prime counters.
// ----------------------------------------------------------------------------
module dmcss_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  dmcss_pkg::sample_t                sample,
  input  logic [dmcss_pkg::LightW-1:0]      light_threshold,
  output dmcss_pkg::result_t                res
);

  logic                             up_armed, down_armed, clear_armed;
  logic                             up_armed_next, down_armed_next, clear_armed_next;
  logic [dmcss_pkg::ValueW-1:0]     decimal_count, prime_count, display_value;
  logic [dmcss_pkg::ValueW-1:0]     decimal_count_next, prime_count_next;
  logic [dmcss_pkg::ValueW-1:0]     display_value_next;
  logic                             up_pre, down_pre, clear_pre;
  logic                             fire_up, fire_down, fire_clear;
  logic [dmcss_pkg::EventW-1:0]     key_event;
  logic                             enabled;
  logic [dmcss_pkg::ValueW-1:0]     decimal_step, prime_step;

  always_comb begin
    up_pre    = up_armed | sample.up_button_n;
    down_pre  = down_armed | sample.down_button_n;
    clear_pre = clear_armed | sample.clear_button_n;

    fire_up    = !sample.up_button_n && up_pre;
    fire_down  = !fire_up && !sample.down_button_n && down_pre;
    fire_clear = !fire_up && !fire_down && !sample.clear_button_n && clear_pre;

    up_armed_next    = up_pre & ~fire_up;
    down_armed_next  = down_pre & ~fire_down;
    clear_armed_next = clear_pre & ~fire_clear;

    if (fire_up) begin
      key_event = dmcss_pkg::EV_UP;
    end else if (fire_down) begin
      key_event = dmcss_pkg::EV_DOWN;
    end else if (fire_clear) begin
      key_event = dmcss_pkg::EV_CLEAR;
    end else begin
      key_event = dmcss_pkg::EV_NONE;
    end

    enabled = sample.light_level >= light_threshold;

    case (key_event)
      dmcss_pkg::EV_UP: begin
        decimal_step = (decimal_count >= dmcss_pkg::DECIMAL_MAX) ? '0 :
                       decimal_count + 7'd1;
        prime_step   = dmcss_pkg::next_prime(prime_count);
      end
      dmcss_pkg::EV_DOWN: begin
        decimal_step = (decimal_count == '0) ? dmcss_pkg::DECIMAL_MAX :
                       decimal_count - 7'd1;
        prime_step   = dmcss_pkg::prev_prime(prime_count);
      end
      dmcss_pkg::EV_CLEAR: begin
        decimal_step = '0;
        prime_step   = '0;
      end
      default: begin
        decimal_step = decimal_count;
        prime_step   = prime_count;
      end
    endcase

    decimal_count_next = decimal_count;
    prime_count_next   = prime_count;
    display_value_next = display_value;
    if (enabled) begin
      if (sample.prime_mode) begin
        prime_count_next   = prime_step;
        display_value_next = prime_step;
      end else begin
        decimal_count_next = decimal_step;
        display_value_next = decimal_step;
      end
    end

    res.key_event   = key_event;
    res.enabled     = enabled;
    res.shown_value = display_value_next;
    res.motor_on    = decimal_count_next == dmcss_pkg::MOTOR_COUNT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_armed      <= 1'b1;
      down_armed    <= 1'b1;
      clear_armed   <= 1'b1;
      decimal_count <= '0;
      prime_count   <= '0;
      display_value <= '0;
    end else if (advance) begin
      up_armed      <= up_armed_next;
      down_armed    <= down_armed_next;
      clear_armed   <= clear_armed_next;
      decimal_count <= decimal_count_next;
      prime_count   <= prime_count_next;
      display_value <= display_value_next;
    end
  end

endmodule

// ===== rtl/dual_mode_counter_seven_segment_top.sv =====
// ----------------------------------------------------------------------------
// dual_mode_counter_seven_segment_top
// Two digit up/down counter, decimal or prime, with seven segment outputs.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid/in_ready carries one sample per item: three
//   active-low button levels, the mode switch and the light level.
//   Output channel out_valid/out_ready returns one result item per sample:
//   key event, enable flag, shown value, both digit patterns, motor flag.
//   cfg_wr_en/cfg_wr_data write the light threshold, taken on the same edge.
//   An accepted item is registered in the sample stage and its result is
//   loaded into the output register when that is free, visible after it.
//   Without output stalls one item per cycle is sustained; the counter
//   update is a single pass of logic between the sample and output registers.
//   Reset arms all buttons, clears both counters and the shown value, sets
//   the threshold to 500 and empties both stages.
//   When out_ready is low the result is held; the sample stage still takes
//   one more item, then in_ready drops until the output is taken.
// ----------------------------------------------------------------------------
module dual_mode_counter_seven_segment_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [dmcss_pkg::LightW-1:0]       cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               up_button_n,
  input  logic                               down_button_n,
  input  logic                               clear_button_n,
  input  logic                               prime_mode,
  input  logic [dmcss_pkg::LightW-1:0]       light_level,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dmcss_pkg::EventW-1:0]       key_event,
  output logic                               enabled,
  output logic [dmcss_pkg::ValueW-1:0]       shown_value,
  output logic [dmcss_pkg::SegW-1:0]         tens_segments,
  output logic [dmcss_pkg::SegW-1:0]         units_segments,
  output logic                               motor_on
);

  logic [dmcss_pkg::LightW-1:0] light_threshold;
  logic                         s1_valid;
  dmcss_pkg::sample_t           s1_sample;
  logic                         out_load;
  dmcss_pkg::result_t           res;
  logic [14:0]                  tens_prod;
  logic [dmcss_pkg::DigitW-1:0] tens_digit, units_digit;
  logic [dmcss_pkg::ValueW-1:0] tens_times_ten;

  assign out_load = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_threshold <= dmcss_pkg::THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      light_threshold <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample.up_button_n    <= up_button_n;
      s1_sample.down_button_n  <= down_button_n;
      s1_sample.clear_button_n <= clear_button_n;
      s1_sample.prime_mode     <= prime_mode;
      s1_sample.light_level    <= light_level;
    end
  end

  dmcss_core u_core (
    .clk             (clk),
    .rst             (rst),
    .advance         (s1_valid && out_load),
    .sample          (s1_sample),
    .light_threshold (light_threshold),
    .res             (res)
  );

  // tens by reciprocal multiply, exact for every 7-bit shown value
  always_comb begin
    tens_prod      = 15'({8'd0, res.shown_value} * 15'd205);
    tens_digit     = tens_prod[14:11];
    tens_times_ten = 7'({3'd0, tens_digit} * 7'd10);
    units_digit    = 4'(res.shown_value - tens_times_ten);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      key_event      <= res.key_event;
      enabled        <= res.enabled;
      shown_value    <= res.shown_value;
      motor_on       <= res.motor_on;
      tens_segments  <= dmcss_pkg::seg_of(tens_digit);
      units_segments <= dmcss_pkg::seg_of(units_digit);
    end
  end

endmodule

// ===== rtl/dmcss_checker.sv =====
// ----------------------------------------------------------------------------
// dmcss_checker
// Port level checks of the dual mode counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_mode_counter_seven_segment_top_assert.svh"

module dmcss_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [dmcss_pkg::EventW-1:0]       key_event,
  input logic [dmcss_pkg::ValueW-1:0]       shown_value,
  input logic [dmcss_pkg::SegW-1:0]         tens_segments,
  input logic [dmcss_pkg::SegW-1:0]         units_segments
);

  `DMCSS_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid, "output valid after reset")

  `DMCSS_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

  `DMCSS_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(shown_value) && $stable(key_event) && $stable(units_segments), "stalled item changed")

  `DMCSS_ASSERT(a_zero_digits, out_valid && shown_value == 7'd0 |-> tens_segments == 7'h7E && units_segments == 7'h7E && shown_value <= dmcss_pkg::DECIMAL_MAX, "wrong digits for zero")

endmodule

bind dual_mode_counter_seven_segment_top dmcss_checker u_checker (.*);

// ===== bench/dmcss_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// dmcss_tb_pkg
// Scoreboard for the dual mode counter bench: tracks the button arming,
// both counters and the shown value, and checks every display item in order.
// ----------------------------------------------------------------------------
package dmcss_tb_pkg;

  import dmcss_pkg::*;

  typedef struct packed {
    logic [EventW-1:0] key_event;
    logic              enabled;
    logic [ValueW-1:0] shown_value;
    logic [SegW-1:0]   tens_segments;
    logic [SegW-1:0]   units_segments;
    logic              motor_on;
  } display_t;

  class display_scoreboard;
    logic [LightW-1:0] threshold;
    bit                up_armed;
    bit                down_armed;
    bit                clear_armed;
    logic [ValueW-1:0] decimal_count;
    logic [ValueW-1:0] prime_count;
    logic [ValueW-1:0] display_value;
    display_t          expected_displays[$];
    int                errors;

    function new();
      threshold     = THRESHOLD_RESET;
      up_armed      = 1'b1;
      down_armed    = 1'b1;
      clear_armed   = 1'b1;
      decimal_count = '0;
      prime_count   = '0;
      display_value = '0;
      errors        = 0;
    endfunction

    function void set_threshold(logic [LightW-1:0] value);
      threshold = value;
    endfunction

    function int pending();
      return expected_displays.size();
    endfunction

    function logic [ValueW-1:0] prime_above(logic [ValueW-1:0] c);
      for (int i = 0; i < PrimeTotal; i++) begin
        if (PRIME_TABLE[i] > c) begin
          return PRIME_TABLE[i];
        end
      end
      return '0;
    endfunction

    function logic [ValueW-1:0] prime_below(logic [ValueW-1:0] c);
      if (c > PRIME_TOP) begin
        return PRIME_TOP;
      end
      for (int i = PrimeTotal - 1; i >= 0; i--) begin
        if (PRIME_TABLE[i] < c) begin
          return PRIME_TABLE[i];
        end
      end
      return PRIME_TOP;
    endfunction

    function logic [SegW-1:0] digit_pattern(int unsigned digit);
      return (digit < 10) ? SEG_TABLE[digit] : '0;
    endfunction

    function void note_sample(sample_t s);
      display_t          d;
      logic [EventW-1:0] ev;
      bit                en;
      ev = EV_NONE;
      if (s.up_button_n) begin
        up_armed = 1'b1;
      end
      if (s.down_button_n) begin
        down_armed = 1'b1;
      end
      if (s.clear_button_n) begin
        clear_armed = 1'b1;
      end
      if (!s.up_button_n && up_armed) begin
        up_armed = 1'b0;
        ev = EV_UP;
      end else if (!s.down_button_n && down_armed) begin
        down_armed = 1'b0;
        ev = EV_DOWN;
      end else if (!s.clear_button_n && clear_armed) begin
        clear_armed = 1'b0;
        ev = EV_CLEAR;
      end
      en = (s.light_level >= threshold);
      if (en) begin
        if (!s.prime_mode) begin
          case (ev)
            EV_UP: begin
              decimal_count = (decimal_count >= DECIMAL_MAX) ? '0 : decimal_count + 7'd1;
            end
            EV_DOWN: begin
              decimal_count = (decimal_count == '0) ? DECIMAL_MAX : decimal_count - 7'd1;
            end
            EV_CLEAR: begin
              decimal_count = '0;
            end
            default: ;
          endcase
          display_value = decimal_count;
        end else begin
          case (ev)
            EV_UP: begin
              prime_count = prime_above(prime_count);
            end
            EV_DOWN: begin
              prime_count = prime_below(prime_count);
            end
            EV_CLEAR: begin
              prime_count = '0;
            end
            default: ;
          endcase
          display_value = prime_count;
        end
      end
      d.key_event      = ev;
      d.enabled        = en;
      d.shown_value    = display_value;
      d.tens_segments  = digit_pattern(display_value / 10);
      d.units_segments = digit_pattern(display_value % 10);
      d.motor_on       = (decimal_count == MOTOR_COUNT);
      expected_displays.push_back(d);
    endfunction

    function void compare_field(string field, logic [9:0] want, logic [9:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_display(display_t got);
      display_t want;
      if (expected_displays.size() == 0) begin
        $error("display item with no sample pending");
        errors++;
        return;
      end
      want = expected_displays.pop_front();
      compare_field("key_event", 10'(want.key_event), 10'(got.key_event));
      compare_field("enabled", 10'(want.enabled), 10'(got.enabled));
      compare_field("shown_value", 10'(want.shown_value), 10'(got.shown_value));
      compare_field("tens_segments", 10'(want.tens_segments), 10'(got.tens_segments));
      compare_field("units_segments", 10'(want.units_segments), 10'(got.units_segments));
      compare_field("motor_on", 10'(want.motor_on), 10'(got.motor_on));
    endfunction
  endclass

endpackage

// ===== bench/tb_dual_mode_counter_seven_segment_top.sv =====
// ----------------------------------------------------------------------------
// tb_dual_mode_counter_seven_segment_top
// Drives button, mode and light samples with random gaps and output stalls,
// runs directed wrap, priority and disable cases, then random phases at
// several light thresholds, and checks each display item against the
// scoreboard.
// ----------------------------------------------------------------------------
module tb_dual_mode_counter_seven_segment_top;

  timeunit 1ns;
  timeprecision 1ps;

  import dmcss_pkg::*;
  import dmcss_tb_pkg::*;

  localparam int StallLimit = 2000;
  localparam int PhaseItems = 200;
  localparam logic [LightW-1:0] LightMax = '1;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [LightW-1:0]   cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic                up_button_n;
  logic                down_button_n;
  logic                clear_button_n;
  logic                prime_mode;
  logic [LightW-1:0]   light_level;
  logic                out_valid;
  logic                out_ready;
  logic [EventW-1:0]   key_event;
  logic                enabled;
  logic [ValueW-1:0]   shown_value;
  logic [SegW-1:0]     tens_segments;
  logic [SegW-1:0]     units_segments;
  logic                motor_on;

  display_scoreboard   sb = new();
  bit                  steady;
  int                  stall_cycles;
  logic [LightW-1:0]   threshold_now;
  logic                mode_now;

  dual_mode_counter_seven_segment_top DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .up_button_n    (up_button_n),
    .down_button_n  (down_button_n),
    .clear_button_n (clear_button_n),
    .prime_mode     (prime_mode),
    .light_level    (light_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .key_event      (key_event),
    .enabled        (enabled),
    .shown_value    (shown_value),
    .tens_segments  (tens_segments),
    .units_segments (units_segments),
    .motor_on       (motor_on)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_sample('{up_button_n, down_button_n, clear_button_n, prime_mode,
                         light_level});
      end
      if (out_valid && out_ready) begin
        sb.check_display('{key_event, enabled, shown_value, tens_segments,
                           units_segments, motor_on});
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("dual_mode_counter_seven_segment_top regression: fail");
          $finish;
        end
      end
    end
  end

  task automatic send_sample(input logic up, input logic down, input logic clr,
                             input logic mode, input logic [LightW-1:0] light);
    if (!steady) begin
      while ($urandom_range(99) < 37) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    up_button_n    <= up;
    down_button_n  <= down;
    clear_button_n <= clr;
    prime_mode     <= mode;
    light_level    <= light;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // let every pending display item drain, then settle past the pipeline
  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [LightW-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_threshold(value);
    threshold_now = value;
  endtask

  function automatic logic [LightW-1:0] pick_light();
    int lvl;
    case ($urandom_range(7))
      0: lvl = 0;
      1: lvl = LightMax;
      2, 3: begin
        lvl = int'(threshold_now) + $urandom_range(4) - 2;
        lvl = (lvl < 0) ? 0 : (lvl > int'(LightMax)) ? int'(LightMax) : lvl;
      end
      default: lvl = $urandom_range(LightMax);
    endcase
    return LightW'(lvl);
  endfunction

  task automatic send_random();
    logic up;
    logic down;
    logic clr;
    if ($urandom_range(7) == 0) begin
      mode_now = ~mode_now;
    end
    if ($urandom_range(9) == 0) begin
      // all three pressed together
      up   = 1'b0;
      down = 1'b0;
      clr  = 1'b0;
    end else begin
      up   = 1'($urandom_range(1));
      down = 1'($urandom_range(1));
      clr  = ($urandom_range(3) != 0);
    end
    send_sample(up, down, clr, mode_now, pick_light());
  endtask

  initial begin
    logic [LightW-1:0] phase_threshold [4];
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    up_button_n    = 1'b1;
    down_button_n  = 1'b1;
    clear_button_n = 1'b1;
    prime_mode     = 1'b0;
    light_level    = '0;
    out_ready      = 1'b0;
    steady         = 1'b0;
    stall_cycles   = 0;
    threshold_now  = THRESHOLD_RESET;
    mode_now       = 1'b0;
    phase_threshold[0] = '0;
    phase_threshold[1] = LightMax;
    phase_threshold[2] = LightW'($urandom_range(LightMax));
    phase_threshold[3] = THRESHOLD_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // decimal wrap down from 0 and up from 99
    send_sample(1'b1, 1'b1, 1'b1, 1'b0, LightMax);
    send_sample(1'b1, 1'b0, 1'b1, 1'b0, LightMax);
    send_sample(1'b1, 1'b1, 1'b1, 1'b0, LightMax);
    send_sample(1'b0, 1'b1, 1'b1, 1'b0, LightMax);
    // all pressed in prime mode: up, down, clear on successive items
    send_sample(1'b1, 1'b1, 1'b1, 1'b1, LightMax);
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, LightMax);
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, LightMax);
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, LightMax);
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, LightMax);
    send_sample(1'b1, 1'b1, 1'b1, 1'b1, '0);
    // prime down from 0, then up from the top
    send_sample(1'b1, 1'b0, 1'b1, 1'b1, LightMax);
    send_sample(1'b1, 1'b1, 1'b1, 1'b1, LightMax);
    send_sample(1'b0, 1'b1, 1'b1, 1'b1, LightMax);
    send_sample(1'b1, 1'b1, 1'b1, 1'b1, LightMax);
    // event consumed while dark, then threshold edges
    send_sample(1'b0, 1'b1, 1'b1, 1'b0, '0);
    send_sample(1'b1, 1'b1, 1'b1, 1'b0, THRESHOLD_RESET - 10'd1);
    send_sample(1'b0, 1'b1, 1'b1, 1'b0, THRESHOLD_RESET);
    // count up to the motor value
    repeat (4) begin
      send_sample(1'b1, 1'b1, 1'b1, 1'b0, LightMax);
      send_sample(1'b0, 1'b1, 1'b1, 1'b0, LightMax);
    end

    for (int p = 0; p < 4; p++) begin
      drain();
      write_threshold(phase_threshold[p]);
      steady = (p == 2);
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 2 && i == PhaseItems / 2) begin
          steady = 1'b0;
        end
        send_random();
      end
    end
    steady = 1'b0;
    drain();

    if (sb.pending() != 0) begin
      $error("%0d display items never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("dual_mode_counter_seven_segment_top regression: pass");
    end else begin
      $display("dual_mode_counter_seven_segment_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dmcss_pkg.sv
rtl/dmcss_core.sv
rtl/dual_mode_counter_seven_segment_top.sv
rtl/dmcss_checker.sv
bench/dmcss_tb_pkg.sv
bench/tb_dual_mode_counter_seven_segment_top.sv
